@@ src/request_slot_lifecycle_table_top_defines.svh @@
// ----------------------------------------------------------------------------
// request slot lifecycle table assertion macros
// shared property wrappers for the rtl checks, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef REQUEST_SLOT_LIFECYCLE_TABLE_TOP_DEFINES_SVH
`define REQUEST_SLOT_LIFECYCLE_TABLE_TOP_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RSLT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define RSLT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/rslt_pkg.sv @@
// ----------------------------------------------------------------------------
// rslt_pkg
// types, codes and helpers shared by the request slot table modules
// ----------------------------------------------------------------------------
package rslt_pkg;

  // table geometry
  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);

  // field widths
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 4;
  localparam int KIND_W = 8;
  localparam int TAG_W  = 32;
  localparam int STAT_W = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS    = CMD_W + SLOT_W + KIND_W + TAG_W;
  localparam int OUT_BITS   = STAT_W + SLOT_W + KIND_W + TAG_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_DONE    = 2'd2,
    CMD_QUERY   = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    RES_OK    = 2'd0,
    RES_FAIL  = 2'd1,
    RES_PARAM = 2'd2
  } res_status_t;

  // slot lifecycle states
  typedef enum logic [1:0] {
    SLOT_FREE   = 2'd0,
    SLOT_QUEUED = 2'd1,
    SLOT_TAKEN  = 2'd2,
    SLOT_DONE   = 2'd3
  } slot_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input transfer
    logic commit;   // apply the command and load the result register
  } dp_cmd_t;

  // priority search result
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } find_t;

  // lowest set bit of a slot vector
  function automatic find_t find_first(input logic [SLOTS-1:0] vec);
    find_t r;
    r.hit = 1'b0;
    r.idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        r.hit = 1'b1;
        r.idx = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ src/request_slot_lifecycle_table_top.sv @@
// ----------------------------------------------------------------------------
// request_slot_lifecycle_table_top
// table of request slots cycling free, queued, taken, done under four commands
// ----------------------------------------------------------------------------
//   channel   dir  signals                     contents
//   s_*       in   s_tvalid s_tready s_tdata   command, slot_index, kind, tag
//   m_*       out  m_tvalid m_tready m_tdata   status, slot, out_kind, out_tag
//
// one item at a time: the transfer is latched while idle, then the parallel
// priority searches over the slot state flops and the write-back run in exec.
// the result sits in an output register; a stalled output holds the next item
// in the execute step until the register is taken.
// reset clears all slot states to free and the search start to zero; kind
// and tag entries are not cleared.
// ----------------------------------------------------------------------------
module request_slot_lifecycle_table_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // command[1:0], slot_index[5:2], request_kind[13:6], request_tag[45:14]
  input  logic [rslt_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[1:0], slot[5:2], out_kind[13:6], out_tag[45:14]
  output logic [rslt_pkg::OUT_DATA_W-1:0]   m_tdata
);

  rslt_pkg::dp_cmd_t dp_cmd;

  // handshake controller
  rslt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (dp_cmd)
  );

  // slot table datapath
  rslt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (dp_cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

@@ src/rslt_ctrl.sv @@
// ----------------------------------------------------------------------------
// rslt_ctrl
// handshake controller: takes one transfer, waits for the result slot, commits
// ----------------------------------------------------------------------------
`include "request_slot_lifecycle_table_top_defines.svh"

module rslt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output rslt_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  // handshake and datapath commands
  always_comb begin
    s_tready    = (state == S_IDLE);
    cmd.capture = s_tvalid && s_tready;
    cmd.commit  = (state == S_EXEC) && (!out_valid || m_tready);
  end

  // next state and output valid
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (m_tready) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next     = S_IDLE;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  // checks
  `RSLT_ASSERT_NEXT(a_no_second_take, cmd.capture, !s_tready, "transfer taken while busy")
  `RSLT_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid, "committed result not presented")
  `RSLT_ASSERT_SAME(a_no_overwrite, m_tvalid && !m_tready, !cmd.commit, "result overwritten")

endmodule

@@ src/rslt_dp.sv @@
// ----------------------------------------------------------------------------
// rslt_dp
// slot table datapath: state flops, kind and tag store, searches, result reg
// ----------------------------------------------------------------------------
`include "request_slot_lifecycle_table_top_defines.svh"

module rslt_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rslt_pkg::dp_cmd_t                     cmd,
  input  logic [rslt_pkg::IN_DATA_W-1:0]        in_data,
  output logic [rslt_pkg::OUT_DATA_W-1:0]       out_data
);

  // captured input fields
  rslt_pkg::cmd_t                in_cmd;
  logic [rslt_pkg::SLOT_W-1:0]   in_idx;
  logic [rslt_pkg::KIND_W-1:0]   in_kind;
  logic [rslt_pkg::TAG_W-1:0]    in_tag;

  // table storage
  rslt_pkg::slot_state_t [rslt_pkg::SLOTS-1:0] slot_state;
  logic [rslt_pkg::KIND_W-1:0] kind_mem [rslt_pkg::SLOTS];
  logic [rslt_pkg::TAG_W-1:0]  tag_mem  [rslt_pkg::SLOTS];
  logic [rslt_pkg::IDX_W-1:0]  search_start;

  // search vectors
  logic [rslt_pkg::SLOTS-1:0] free_vec;
  logic [rslt_pkg::SLOTS-1:0] queued_vec;
  logic [rslt_pkg::SLOTS-1:0] match_vec;
  logic [rslt_pkg::SLOTS-1:0] upper_vec;
  rslt_pkg::find_t            free_hi;
  rslt_pkg::find_t            free_any;
  rslt_pkg::find_t            enq_pick;
  rslt_pkg::find_t            deq_pick;
  rslt_pkg::find_t            qry_pick;
  logic                       done_ok;

  // next result and write controls
  rslt_pkg::res_status_t       res_status_next;
  logic [rslt_pkg::SLOT_W-1:0] res_slot_next;
  logic [rslt_pkg::KIND_W-1:0] res_kind_next;
  logic [rslt_pkg::TAG_W-1:0]  res_tag_next;
  logic                        st_we;
  logic                        mem_we;
  logic [rslt_pkg::IDX_W-1:0]  wr_idx;
  rslt_pkg::slot_state_t       wr_state;

  // result register
  rslt_pkg::res_status_t       res_status;
  logic [rslt_pkg::SLOT_W-1:0] res_slot;
  logic [rslt_pkg::KIND_W-1:0] res_kind;
  logic [rslt_pkg::TAG_W-1:0]  res_tag;

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_cmd  <= rslt_pkg::cmd_t'(in_data[1:0]);
      in_idx  <= in_data[5:2];
      in_kind <= in_data[13:6];
      in_tag  <= in_data[45:14];
    end
  end

  // per-slot match vectors
  always_comb begin
    for (int i = 0; i < rslt_pkg::SLOTS; i++) begin
      free_vec[i]   = (slot_state[i] == rslt_pkg::SLOT_FREE);
      queued_vec[i] = (slot_state[i] == rslt_pkg::SLOT_QUEUED);
      match_vec[i]  = (slot_state[i] == rslt_pkg::SLOT_DONE) &&
                      (kind_mem[i] == in_kind) && (tag_mem[i] == in_tag);
      upper_vec[i]  = (rslt_pkg::IDX_W'(i) >= search_start);
    end
  end

  // priority searches; circular enqueue search prefers slots at or above start
  always_comb begin
    free_hi  = rslt_pkg::find_first(free_vec & upper_vec);
    free_any = rslt_pkg::find_first(free_vec);
    enq_pick = free_hi.hit ? free_hi : free_any;
    deq_pick = rslt_pkg::find_first(queued_vec);
    qry_pick = rslt_pkg::find_first(match_vec);
    done_ok  = ({1'b0, in_idx} < (rslt_pkg::SLOT_W + 1)'(rslt_pkg::SLOTS)) &&
               (slot_state[in_idx[rslt_pkg::IDX_W-1:0]] == rslt_pkg::SLOT_TAKEN);
  end

  // command decode
  always_comb begin
    res_status_next = rslt_pkg::RES_FAIL;
    res_slot_next   = '0;
    res_kind_next   = '0;
    res_tag_next    = '0;
    st_we           = 1'b0;
    mem_we          = 1'b0;
    wr_idx          = '0;
    wr_state        = rslt_pkg::SLOT_FREE;
    case (in_cmd)
      rslt_pkg::CMD_ENQUEUE: begin
        if (enq_pick.hit) begin
          res_status_next = rslt_pkg::RES_OK;
          res_slot_next   = rslt_pkg::SLOT_W'(enq_pick.idx);
          st_we           = 1'b1;
          mem_we          = 1'b1;
          wr_idx          = enq_pick.idx;
          wr_state        = rslt_pkg::SLOT_QUEUED;
        end
      end
      rslt_pkg::CMD_DEQUEUE: begin
        if (deq_pick.hit) begin
          res_status_next = rslt_pkg::RES_OK;
          res_slot_next   = rslt_pkg::SLOT_W'(deq_pick.idx);
          res_kind_next   = kind_mem[deq_pick.idx];
          res_tag_next    = tag_mem[deq_pick.idx];
          st_we           = 1'b1;
          wr_idx          = deq_pick.idx;
          wr_state        = rslt_pkg::SLOT_TAKEN;
        end
      end
      rslt_pkg::CMD_DONE: begin
        if (done_ok) begin
          res_status_next = rslt_pkg::RES_OK;
          res_slot_next   = in_idx;
          st_we           = 1'b1;
          wr_idx          = in_idx[rslt_pkg::IDX_W-1:0];
          wr_state        = rslt_pkg::SLOT_DONE;
        end
      end
      rslt_pkg::CMD_QUERY: begin
        if (in_tag == '0) begin
          res_status_next = rslt_pkg::RES_PARAM;
        end else if (qry_pick.hit) begin
          res_status_next = rslt_pkg::RES_OK;
          res_slot_next   = rslt_pkg::SLOT_W'(qry_pick.idx);
          st_we           = 1'b1;
          wr_idx          = qry_pick.idx;
          wr_state        = rslt_pkg::SLOT_FREE;
        end
      end
      default: begin
        res_status_next = rslt_pkg::RES_FAIL;
      end
    endcase
  end

  // slot states and enqueue search start
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_state   <= {rslt_pkg::SLOTS{rslt_pkg::SLOT_FREE}};
      search_start <= '0;
    end else if (cmd.commit) begin
      if (st_we) begin
        slot_state[wr_idx] <= wr_state;
      end
      if (mem_we) begin
        search_start <= wr_idx;
      end
    end
  end

  // kind and tag store
  always_ff @(posedge clk) begin
    if (cmd.commit && mem_we) begin
      kind_mem[wr_idx] <= in_kind;
      tag_mem[wr_idx]  <= in_tag;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_kind   <= res_kind_next;
      res_tag    <= res_tag_next;
    end
  end

  assign out_data = {(rslt_pkg::OUT_DATA_W - rslt_pkg::OUT_BITS)'(0),
                     res_tag, res_kind, res_slot, res_status};

  // checks
  `RSLT_ASSERT_NEXT(a_idle_table, !cmd.commit, $stable(slot_state), "table changed without commit")
  `RSLT_ASSERT_NEXT(a_fail_keeps, cmd.commit && res_status_next != rslt_pkg::RES_OK, $stable(slot_state), "failed command changed table")
  `RSLT_ASSERT_NEXT(a_enq_start, cmd.commit && mem_we, search_start == $past(wr_idx) && slot_state[search_start] == rslt_pkg::SLOT_QUEUED, "enqueue slot not queued")

endmodule
